@@ rtl/dfmt_pkg.sv @@
// Shared types and constants for the decimal field formatter.
// Used by dfmt_front, dfmt_queue, dfmt_back and decimal_field_formatter_top.
// No dependencies.
package dfmt_pkg;

  // Default and largest number of digit positions in a field.
  localparam int MAX_DIGITS_DEF = 10;

  // Fixed field widths of a request and of a display write.
  localparam int VALUE_W  = 32;
  localparam int BIT_CNT_W = 5;
  localparam int FIELD_W  = 4;
  localparam int COL_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 8;

  // Job queue depth between the converter and the emitter.
  localparam int QUEUE_DEPTH = 2;

  // Register select codes of a display write.
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Display command base and character codes.
  localparam logic [7:0] CURSOR_BASE  = 8'h80;
  localparam logic [7:0] LINE1_OFFSET = 8'd64;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;

  // Everything of a converted request except its BCD digits.
  typedef struct packed {
    logic                  big;     // value has digits beyond the field storage
    logic [FIELD_W-1:0]    width;   // saturated field width
    logic [FIELD_W-1:0]    places;  // digits after the point
    logic [BYTE_W-1:0]     cursor;  // cursor command byte
  } job_hdr_t;

  localparam int HDR_W = $bits(job_hdr_t);

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ rtl/dfmt_front.sv @@
// Request front end: accepts a request and converts its value to BCD
// with a shift-and-add-3 pass, one bit per cycle, then queues the job.
// Depends on dfmt_pkg.
module dfmt_front #(
  parameter int MAX_DIGITS = dfmt_pkg::MAX_DIGITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // value[31:0], width[35:32], places[39:36], line_sel[40], column[46:41]
  input  logic [dfmt_pkg::S_DATA_W-1:0]       s_tdata,
  output logic                                push,
  output logic [MAX_DIGITS-1:0][3:0]          push_digits,
  output dfmt_pkg::job_hdr_t                  push_hdr,
  input  dfmt_pkg::queue_stat_t               q_stat
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  localparam logic [dfmt_pkg::BIT_CNT_W-1:0] CNT_LAST =
    dfmt_pkg::BIT_CNT_W'(dfmt_pkg::VALUE_W - 1);
  localparam logic [dfmt_pkg::FIELD_W-1:0] WIDTH_MAX =
    dfmt_pkg::FIELD_W'(MAX_DIGITS);

  front_state_t                     state;
  logic [dfmt_pkg::BIT_CNT_W-1:0]   cnt;
  logic [dfmt_pkg::VALUE_W-1:0]     shreg;
  logic [MAX_DIGITS-1:0][3:0]       bcd;
  logic                             big;
  logic [dfmt_pkg::FIELD_W-1:0]     width_r;
  logic [dfmt_pkg::FIELD_W-1:0]     places_r;
  logic [dfmt_pkg::BYTE_W-1:0]      cursor_r;
  logic [MAX_DIGITS-1:0][3:0]       bcd_adj;
  logic [4*MAX_DIGITS:0]            bcd_shift;

  logic [dfmt_pkg::FIELD_W-1:0]     in_width;
  logic                             in_line;
  logic [dfmt_pkg::COL_W-1:0]       in_col;

  assign in_width = s_tdata[35:32];
  assign in_line  = s_tdata[40];
  assign in_col   = s_tdata[46:41];

  // Add 3 to every digit of 5 or more before the next shift.
  always_comb begin
    for (int j = 0; j < MAX_DIGITS; j++) begin
      bcd_adj[j] = (bcd[j] >= 4'd5) ? bcd[j] + 4'd3 : bcd[j];
    end
  end

  // Adjusted digits shifted up by one with the next value bit entering at the bottom.
  assign bcd_shift = {bcd_adj, shreg[dfmt_pkg::VALUE_W-1]};

  assign s_tready    = (state == F_IDLE);
  assign push        = (state == F_PUSH) && !q_stat.full;
  assign push_digits = bcd;
  assign push_hdr    = '{big: big, width: width_r, places: places_r, cursor: cursor_r};

  // Sequencer: capture, 32 conversion steps, then hand the job to the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            shreg    <= s_tdata[dfmt_pkg::VALUE_W-1:0];
            width_r  <= (in_width > WIDTH_MAX) ? WIDTH_MAX : in_width;
            places_r <= s_tdata[39:36];
            cursor_r <= dfmt_pkg::CURSOR_BASE
                        + (in_line ? dfmt_pkg::LINE1_OFFSET : 8'd0)
                        + {2'b00, in_col};
            bcd      <= '0;
            big      <= 1'b0;
            cnt      <= '0;
            state    <= F_CONV;
          end
        end
        F_CONV: begin
          bcd   <= bcd_shift[4*MAX_DIGITS-1:0];
          big   <= big | bcd_shift[4*MAX_DIGITS];
          shreg <= {shreg[dfmt_pkg::VALUE_W-2:0], 1'b0};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/dfmt_queue.sv @@
// Short job queue between the converter and the write emitter.
// Depends on dfmt_pkg for its depth and status type.
module dfmt_queue #(
  parameter int DATA_W = 57
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_W-1:0]     push_data,
  input  logic                  pop,
  output logic [DATA_W-1:0]     pop_data,
  output dfmt_pkg::queue_stat_t stat
);

  localparam int DEPTH = dfmt_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign stat.full  = (count == CNT_FULL);
  assign stat.empty = (count == '0);
  assign pop_data   = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/dfmt_back.sv @@
// Write emitter: takes converted jobs from the queue and sends the cursor
// command, the point and the blanked digits through an output register.
// Depends on dfmt_pkg.
module dfmt_back #(
  parameter int MAX_DIGITS = dfmt_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dfmt_pkg::queue_stat_t          q_stat,
  output logic                           pop,
  input  logic [MAX_DIGITS-1:0][3:0]     pop_digits,
  input  dfmt_pkg::job_hdr_t             pop_hdr,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // byte_out[7:0]
  output logic [dfmt_pkg::M_DATA_W-1:0]  m_tdata,
  // reg_select[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_CURSOR,
    B_DIGITS
  } back_state_t;

  localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  back_state_t                   state;
  logic [MAX_DIGITS-1:0][3:0]    digits_r;
  dfmt_pkg::job_hdr_t            hdr_r;
  logic [dfmt_pkg::FIELD_W-1:0]  k;
  logic                          dot_done;

  logic                          adv;
  logic [MAX_DIGITS-1:0]         dnz;
  logic [MAX_DIGITS-1:0]         nz_above;
  logic [DIG_W-1:0]              kidx;
  logic [3:0]                    dsel;
  logic                          show;
  logic                          dot_here;
  logic [dfmt_pkg::BYTE_W-1:0]   ch;

  assign pop = (state == B_IDLE) && !q_stat.empty;
  assign adv = !m_tvalid || m_tready;

  // A digit position shows its digit when any digit at or above it is nonzero or the value is big.
  always_comb begin
    for (int j = 0; j < MAX_DIGITS; j++) begin
      dnz[j] = |digits_r[j];
    end
    for (int j = 0; j < MAX_DIGITS; j++) begin
      nz_above[j] = hdr_r.big | (|(dnz >> j));
    end
  end

  // Character for the digit position k places from the right.
  assign kidx     = k[DIG_W-1:0];
  assign dsel     = digits_r[kidx];
  assign show     = nz_above[kidx] || (k <= hdr_r.places);
  assign ch       = show ? dfmt_pkg::CHAR_ZERO + {4'b0000, dsel} : dfmt_pkg::CHAR_SPACE;
  assign dot_here = (hdr_r.places != '0) && (k == hdr_r.places - 4'd1) && !dot_done;

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          // The output register empties once its write is taken.
          if (adv) begin
            m_tvalid <= 1'b0;
          end
          if (pop) begin
            digits_r <= pop_digits;
            hdr_r    <= pop_hdr;
            state    <= B_CURSOR;
          end
        end
        B_CURSOR: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tuser  <= dfmt_pkg::RS_CMD;
            m_tdata  <= hdr_r.cursor;
            m_tlast  <= (hdr_r.width == '0);
            dot_done <= 1'b0;
            k        <= hdr_r.width - 4'd1;
            state    <= (hdr_r.width == '0) ? B_IDLE : B_DIGITS;
          end
        end
        B_DIGITS: begin
          if (adv) begin
            m_tvalid <= 1'b1;
            m_tuser  <= dfmt_pkg::RS_DATA;
            if (dot_here) begin
              m_tdata  <= dfmt_pkg::CHAR_POINT;
              m_tlast  <= 1'b0;
              dot_done <= 1'b1;
            end else begin
              m_tdata  <= ch;
              m_tlast  <= (k == '0);
              dot_done <= 1'b0;
              if (k == '0) begin
                state <= B_IDLE;
              end else begin
                k <= k - 4'd1;
              end
            end
          end
        end
        default: begin
          if (adv) begin
            m_tvalid <= 1'b0;
          end
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/decimal_field_formatter_top.sv @@
// Decimal field formatter: a request is converted bit by bit and then queued;
// the emitter then sends its writes one per cycle while the receiver is ready,
// up to 12 writes in all. The bit-serial BCD converter sets the throughput:
// it takes a new request once the last one is queued, with emission of one
// job overlapping conversion of the next through a two-entry queue.
// Synchronous active-high reset empties the queue and idles both sides.
module decimal_field_formatter_top #(
  parameter int MAX_DIGITS = dfmt_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // value[31:0], width[35:32], places[39:36], line_sel[40], column[46:41]
  input  logic [dfmt_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // byte_out[7:0]
  output logic [dfmt_pkg::M_DATA_W-1:0]  m_tdata,
  // reg_select[0]
  output logic                           m_tuser,
  output logic                           m_tlast
);

  localparam int JOB_W = 4 * MAX_DIGITS + dfmt_pkg::HDR_W;

  logic                        push;
  logic [MAX_DIGITS-1:0][3:0]  push_digits;
  dfmt_pkg::job_hdr_t          push_hdr;
  logic                        pop;
  logic [MAX_DIGITS-1:0][3:0]  pop_digits;
  dfmt_pkg::job_hdr_t          pop_hdr;
  logic [JOB_W-1:0]            pop_data;
  dfmt_pkg::queue_stat_t       q_stat;
  logic                        expect_cmd;

  dfmt_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .push        (push),
    .push_digits (push_digits),
    .push_hdr    (push_hdr),
    .q_stat      (q_stat)
  );

  dfmt_queue #(.DATA_W(JOB_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_digits, push_hdr}),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  assign pop_digits = pop_data[JOB_W-1:dfmt_pkg::HDR_W];
  assign pop_hdr    = pop_data[dfmt_pkg::HDR_W-1:0];

  dfmt_back #(.MAX_DIGITS(MAX_DIGITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .pop        (pop),
    .pop_digits (pop_digits),
    .pop_hdr    (pop_hdr),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  // Tracks whether the next write must open a new request with a cursor command.
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_cmd <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      expect_cmd <= m_tlast;
    end
  end

  // A cursor command appears exactly at the start of each request's writes.
  a_cmd_framing: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == dfmt_pkg::RS_CMD) == expect_cmd))
    else $error("cursor command out of place in the write stream");

  // The converter never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full))
    else $error("job queue overflow");

  // The front end goes busy right after taking a request.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("front end ready during conversion");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for decimal_field_formatter_top: random and directed
// format requests, a scoreboard class that predicts every display write.
// Depends on dfmt_pkg and the formatter RTL.
module testbench;

  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_COUNT = 150;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 300000;

  // One display write as it leaves the block.
  typedef struct packed {
    logic                        rs;
    logic [dfmt_pkg::BYTE_W-1:0] data;
    logic                        last;
  } display_write_t;

  // Predicts the writes of each accepted request and checks the output stream.
  class display_write_scoreboard;
    display_write_t expected_writes[$];
    int unsigned    failures = 0;

    function void predict_request(logic [dfmt_pkg::S_DATA_W-1:0] req);
      logic [dfmt_pkg::VALUE_W-1:0] num;
      logic [dfmt_pkg::VALUE_W-1:0] digit;
      logic [dfmt_pkg::BYTE_W-1:0]  chars[dfmt_pkg::MAX_DIGITS_DEF];
      logic [dfmt_pkg::BYTE_W-1:0]  cursor;
      int                           w;
      int                           pl;
      int                           pos;
      num = req[31:0];
      w   = int'(req[35:32]);
      pl  = int'(req[39:36]);
      if (w > dfmt_pkg::MAX_DIGITS_DEF) begin
        w = dfmt_pkg::MAX_DIGITS_DEF;
      end
      // Build the field from the right; leading zeros blank outside the places+1 digits.
      for (pos = 0; pos < w; pos++) begin
        digit = num % 10;
        if (num != 0 || pos <= pl) begin
          chars[w - 1 - pos] = dfmt_pkg::CHAR_ZERO + digit[dfmt_pkg::BYTE_W-1:0];
        end else begin
          chars[w - 1 - pos] = dfmt_pkg::CHAR_SPACE;
        end
        num = num / 10;
      end
      cursor = dfmt_pkg::CURSOR_BASE + (req[40] ? dfmt_pkg::LINE1_OFFSET : 8'd0)
               + {2'b00, req[46:41]};
      expected_writes.push_back('{rs: dfmt_pkg::RS_CMD, data: cursor, last: (w == 0)});
      // Digits most significant first, with the point ahead of the fractional group.
      for (pos = 0; pos < w; pos++) begin
        if (pl != 0 && (w - pos) == pl) begin
          expected_writes.push_back('{rs: dfmt_pkg::RS_DATA, data: dfmt_pkg::CHAR_POINT,
                                      last: 1'b0});
        end
        expected_writes.push_back('{rs: dfmt_pkg::RS_DATA, data: chars[pos],
                                    last: (pos == w - 1)});
      end
    endfunction

    function void check_write(display_write_t got);
      display_write_t want;
      if (expected_writes.size() == 0) begin
        failures++;
        $display("%0t: unexpected write rs=%0b byte=%h last=%0b",
                 $time, got.rs, got.data, got.last);
        return;
      end
      want = expected_writes.pop_front();
      if (got.rs !== want.rs) begin
        failures++;
        $display("%0t: reg_select expected %0b actual %0b", $time, want.rs, got.rs);
      end
      if (got.data !== want.data) begin
        failures++;
        $display("%0t: byte_out expected %h actual %h", $time, want.data, got.data);
      end
      if (got.last !== want.last) begin
        failures++;
        $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
      end
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [dfmt_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [dfmt_pkg::M_DATA_W-1:0] m_tdata;
  logic                          m_tuser;
  logic                          m_tlast;

  display_write_scoreboard board = new();
  int burst_left = 0;
  int unsigned cycle_count = 0;

  decimal_field_formatter_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Clock with a period of 10 units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("decimal_field_formatter_top regression: fail");
      $finish;
    end
  end

  // Output monitor: every accepted write goes to the scoreboard.
  always @(posedge clk) begin : write_monitor
    display_write_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{rs: m_tuser, data: m_tdata, last: m_tlast};
      board.check_write(got);
    end
  end

  // Receiver: random stall segments, and once a long hold-off that backs up the queue.
  initial begin : receiver
    int seg;
    int mode;
    int len;
    int k;
    seg = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (seg == 6) begin
        m_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(10, 80);
        for (k = 0; k < len; k++) begin
          case (mode)
            0: begin
              m_tready <= 1'b1;
            end
            1: begin
              m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
              m_tready <= (k % 4 != 3);
            end
            default: begin
              m_tready <= ($urandom_range(0, 7) == 0);
            end
          endcase
          @(negedge clk);
        end
      end
      seg++;
    end
  end

  function automatic logic [dfmt_pkg::S_DATA_W-1:0] make_request(
      logic [dfmt_pkg::VALUE_W-1:0] value,
      logic [dfmt_pkg::FIELD_W-1:0] width,
      logic [dfmt_pkg::FIELD_W-1:0] places,
      logic line_sel,
      logic [dfmt_pkg::COL_W-1:0] column);
    return {1'b0, column, line_sel, places, width, value};
  endfunction

  // Offers one request in bursts with random gaps and waits for its acceptance.
  task automatic send_request(logic [dfmt_pkg::S_DATA_W-1:0] req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.predict_request(req);
  endtask

  initial begin : stimulus
    logic [dfmt_pkg::VALUE_W-1:0] value;
    logic [dfmt_pkg::FIELD_W-1:0] width;
    logic [dfmt_pkg::FIELD_W-1:0] places;
    int                           n;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed requests: field extremes, saturation, zero width and point placement.
    send_request(make_request(32'd0, 4'd1, 4'd0, 1'b0, 6'd0));
    send_request(make_request(32'hFFFF_FFFF, 4'd10, 4'd0, 1'b1, 6'd63));
    send_request(make_request(32'hFFFF_FFFF, 4'd15, 4'd15, 1'b0, 6'd42));
    send_request(make_request(32'd1234, 4'd0, 4'd0, 1'b1, 6'd21));
    send_request(make_request(32'd1234, 4'd0, 4'd3, 1'b0, 6'd5));
    send_request(make_request(32'd0, 4'd10, 4'd0, 1'b0, 6'd1));
    send_request(make_request(32'd0, 4'd10, 4'd3, 1'b1, 6'd2));
    send_request(make_request(32'd5, 4'd4, 4'd2, 1'b0, 6'd3));
    send_request(make_request(32'd987654321, 4'd10, 4'd10, 1'b0, 6'd4));
    send_request(make_request(32'd42, 4'd6, 4'd6, 1'b1, 6'd8));
    send_request(make_request(32'd42, 4'd6, 4'd7, 1'b0, 6'd16));
    send_request(make_request(32'd123456, 4'd3, 4'd0, 1'b1, 6'd32));
    send_request(make_request(32'd123456, 4'd3, 4'd1, 1'b0, 6'd48));
    send_request(make_request(32'd1000000000, 4'd10, 4'd9, 1'b1, 6'd10));
    send_request(make_request(32'd7, 4'd1, 4'd1, 1'b0, 6'd60));
    send_request(make_request(32'd99, 4'd2, 4'd1, 1'b1, 6'd30));
    send_request(make_request(32'hFFFF_FFFF, 4'd11, 4'd4, 1'b0, 6'd7));
    send_request(make_request(32'd305419896, 4'd8, 4'd15, 1'b1, 6'd62));
    send_request(make_request(32'd10, 4'd2, 4'd0, 1'b0, 6'd17));
    send_request(make_request(32'd100, 4'd5, 4'd12, 1'b1, 6'd44));

    // Random requests, mostly legal widths with places inside the field.
    for (n = 0; n < RANDOM_COUNT; n++) begin
      case ($urandom_range(0, 5))
        0: begin
          value = $urandom_range(0, 9);
        end
        1: begin
          value = $urandom_range(0, 99999);
        end
        2: begin
          value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        end
        3: begin
          value = $urandom >> $urandom_range(0, 31);
        end
        default: begin
          value = $urandom;
        end
      endcase
      if ($urandom_range(0, 9) == 0) begin
        width = 4'($urandom_range(0, 15));
      end else begin
        width = 4'($urandom_range(1, 10));
      end
      if ($urandom_range(0, 4) == 0) begin
        places = 4'($urandom_range(0, 15));
      end else begin
        places = 4'($urandom_range(0, width));
      end
      send_request(make_request(value, width, places, 1'($urandom_range(0, 1)),
                                6'($urandom_range(0, 63))));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain the remaining writes, then allow the pipeline to settle.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("decimal_field_formatter_top regression: pass");
    end else begin
      $display("decimal_field_formatter_top regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dfmt_pkg.sv
rtl/dfmt_front.sv
rtl/dfmt_queue.sv
rtl/dfmt_back.sv
rtl/decimal_field_formatter_top.sv
sim/testbench.sv
